// File: rtl/bsfr_pkg.sv
package bsfr_pkg;

  localparam int STORE_DEPTH_DEFAULT = 64;

  // fletcher seeds and modulus
  localparam logic [7:0] SEED_ONE = 8'h12;
  localparam logic [7:0] SEED_TWO = 8'h34;
  localparam logic [8:0] MODULUS  = 9'd255;

  // register map
  localparam int          CFG_ADDR_W = 4;
  localparam logic [1:0]  REG_MARK   = 2'd0;
  localparam logic [1:0]  REG_ESCAPE = 2'd1;
  localparam logic [1:0]  REG_UNMASK = 2'd2;

  localparam logic [7:0] MARK_RESET   = 8'd126;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;
  localparam logic [7:0] UNMASK_RESET = 8'd32;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_CHECKSUM = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic          take;
    logic          load_err;
    frame_status_t err_code;
    logic          start_drain;
    logic          rd_en;
    logic          emit_byte;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_mark;
    logic frame_short;
    logic sum_ok;
    logic drain_last;
    logic out_free;
  } dp_status_t;

  // x + y modulo 255, with x below 255
  function automatic logic [7:0] mod255_add(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= MODULUS) begin
      s = s - MODULUS;
    end
    return s[7:0];
  endfunction

endpackage

// File: rtl/byte_stuffed_frame_receiver_top.sv
// byte-stuffed frame receiver with a fletcher-style checksum
//
// line channel (line_valid / line_stall / line_byte): one raw link byte per
// transaction. an escape byte arms an xor mask for the next byte, a mark byte
// closes the frame, every other byte is unmasked and kept until the store is
// full. the last kept byte is the frame's checksum.
// result channel (result_valid / result_stall / payload_byte, is_last,
// frame_status): a good frame drains its payload bytes, is_last on the final
// one; a short frame or a checksum mismatch gives a single error transaction.
// data and escape bytes are taken back to back while the result register is
// free. the checksum is kept running as bytes arrive, so the verdict is ready
// at the mark and an error result appears in the cycle after the mark
// transaction. a good frame drains each payload byte through a store read,
// then the result register; line input is held off while draining.
// the block takes a new line byte while a finished result still sits in the
// result register, provided that result is being taken in the same cycle.
// reset: registers return to mark 126, escape 125, unmask 32, the byte count
// and escape mask clear; the payload store is not cleared.
// a stalled result holds in its register, and input stalls behind it.
module byte_stuffed_frame_receiver_top
  import bsfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // line channel
  input  logic                  line_valid,
  output logic                  line_stall,
  input  logic [7:0]            line_byte,
  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [7:0]            payload_byte,
  output logic                  is_last,
  output logic [1:0]            frame_status,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] mark_code;
  logic [7:0] escape_code;
  logic [7:0] unmask_value;
  logic       cfg_write;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // no wait states on the configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register bank, word index taken from paddr[3:2]; the unused slot is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_code    <= MARK_RESET;
      escape_code  <= ESCAPE_RESET;
      unmask_value <= UNMASK_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_MARK:   mark_code    <= pwdata[7:0];
        REG_ESCAPE: escape_code  <= pwdata[7:0];
        REG_UNMASK: unmask_value <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_MARK:   prdata = {24'd0, mark_code};
      REG_ESCAPE: prdata = {24'd0, escape_code};
      REG_UNMASK: prdata = {24'd0, unmask_value};
      default:    prdata = '0;
    endcase
  end

  // sequencing of frame close and drain
  bsfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .status     (status),
    .line_stall (line_stall),
    .cmd        (cmd)
  );

  // byte decode, store, running checksum and result register
  bsfr_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .line_byte    (line_byte),
    .mark_code    (mark_code),
    .escape_code  (escape_code),
    .unmask_value (unmask_value),
    .result_stall (result_stall),
    .status       (status),
    .result_valid (result_valid),
    .payload_byte (payload_byte),
    .is_last      (is_last),
    .frame_status (frame_status)
  );

endmodule

// File: rtl/bsfr_ctrl.sv
module bsfr_ctrl
  import bsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       line_valid,
  input  dp_status_t status,
  output logic       line_stall,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (line_valid && status.out_free && status.is_mark &&
            !status.frame_short && status.sum_ok) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.drain_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.err_code = STATUS_GOOD;
    line_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        line_stall = !status.out_free;
        cmd.take   = line_valid && status.out_free;
        if (cmd.take && status.is_mark) begin
          priority if (status.frame_short) begin
            cmd.load_err = 1'b1;
            cmd.err_code = STATUS_SHORT;
          end else if (!status.sum_ok) begin
            cmd.load_err = 1'b1;
            cmd.err_code = STATUS_CHECKSUM;
          end else begin
            cmd.start_drain = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.rd_en = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_byte = status.out_free;
      end
      default: begin
        line_stall = 1'b1;
      end
    endcase
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> state == ST_IDLE)
    else $error("input taken outside idle");

  a_fetch_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |=> state == ST_EMIT)
    else $error("fetch not followed by emit");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_err && cmd.emit_byte))
    else $error("error and byte loaded together");

endmodule

// File: rtl/bsfr_dpath.sv
module bsfr_dpath
  import bsfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  logic [7:0] line_byte,
  input  logic [7:0] mark_code,
  input  logic [7:0] escape_code,
  input  logic [7:0] unmask_value,
  input  logic       result_stall,
  output dp_status_t status,
  output logic       result_valid,
  output logic [7:0] payload_byte,
  output logic       is_last,
  output logic [1:0] frame_status
);

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

  logic [7:0]        store_mem [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic [CNT_W-1:0]  stored_count;
  logic [7:0]        escape_pending;
  logic [7:0]        sum_a;
  logic [7:0]        sum_b;
  logic [7:0]        prev_a;
  logic [7:0]        prev_b;
  logic [7:0]        last_byte;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] drain_end;

  logic       is_escape;
  logic       store_full;
  logic       do_store;
  logic [7:0] data_byte;
  logic [7:0] sum_a_next;
  logic [7:0] sum_b_next;

  assign status.is_mark     = (line_byte == mark_code);
  assign is_escape          = (line_byte == escape_code);
  assign store_full         = (stored_count == CNT_W'(STORE_DEPTH));
  assign status.frame_short = (stored_count < CNT_W'(2));
  // prev sums cover all stored bytes but the last one
  assign status.sum_ok      = ((prev_a ^ prev_b) == last_byte);
  assign status.drain_last  = (rd_ptr == drain_end);
  assign status.out_free    = !result_valid || !result_stall;

  assign do_store   = cmd.take && !status.is_mark && !is_escape && !store_full;
  assign data_byte  = line_byte ^ escape_pending;
  assign sum_a_next = mod255_add(sum_a, data_byte);
  assign sum_b_next = mod255_add(sum_b, sum_a_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count   <= '0;
      escape_pending <= '0;
      sum_a          <= SEED_ONE;
      sum_b          <= SEED_TWO;
    end else if (cmd.take) begin
      if (status.is_mark) begin
        stored_count   <= '0;
        escape_pending <= '0;
        sum_a          <= SEED_ONE;
        sum_b          <= SEED_TWO;
      end else if (is_escape) begin
        escape_pending <= unmask_value;
      end else if (!store_full) begin
        stored_count   <= stored_count + CNT_W'(1);
        escape_pending <= '0;
        sum_a          <= sum_a_next;
        sum_b          <= sum_b_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      prev_a    <= sum_a;
      prev_b    <= sum_b;
      last_byte <= data_byte;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (do_store) begin
      store_mem[stored_count[ADDR_W-1:0]] <= data_byte;
    end
    if (cmd.rd_en) begin
      rd_data <= store_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_drain) begin
      rd_ptr    <= '0;
      drain_end <= ADDR_W'(stored_count - CNT_W'(2));
    end else if (cmd.emit_byte) begin
      rd_ptr <= rd_ptr + ADDR_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_err || cmd.emit_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      payload_byte <= '0;
      is_last      <= 1'b1;
      frame_status <= cmd.err_code;
    end else if (cmd.emit_byte) begin
      payload_byte <= rd_data;
      is_last      <= status.drain_last;
      frame_status <= STATUS_GOOD;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(STORE_DEPTH))
    else $error("stored count beyond store depth");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_status != STATUS_GOOD |-> is_last && payload_byte == 8'd0)
    else $error("malformed error result");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load_err || cmd.emit_byte |-> status.out_free)
    else $error("result register overwritten");

endmodule

// File: test/tb_byte_stuffed_frame_receiver_top.sv
`timescale 1ns / 100ps

import bsfr_pkg::*;

typedef struct packed {
  logic [7:0]    data;
  logic          last;
  frame_status_t status;
} frame_result_t;

// predicts what the receiver returns and checks it in arrival order
class frame_scoreboard;
  logic [7:0]    mark;
  logic [7:0]    escape;
  logic [7:0]    unmask;
  logic [7:0]    kept[$];
  logic [7:0]    mask;
  frame_result_t pending[$];
  int            faults;

  function new();
    mark   = MARK_RESET;
    escape = ESCAPE_RESET;
    unmask = UNMASK_RESET;
    mask   = 8'h00;
    faults = 0;
  endfunction

  function void set_register(input logic [1:0] idx, input logic [7:0] value);
    case (idx)
      REG_MARK: begin
        mark = value;
      end
      REG_ESCAPE: begin
        escape = value;
      end
      REG_UNMASK: begin
        unmask = value;
      end
      default: begin
      end
    endcase
  endfunction

  // mod-255 running sums over the first n bytes, folded by xor
  static function logic [7:0] fletcher_check(input logic [7:0] bytes[$], input int n);
    int a;
    int b;
    a = SEED_ONE;
    b = SEED_TWO;
    for (int i = 0; i < n; i++) begin
      a = (a + bytes[i]) % 255;
      b = (b + a) % 255;
    end
    return 8'(a ^ b);
  endfunction

  function void note_byte(input logic [7:0] b);
    int len;
    if (b == mark) begin
      if (kept.size() < 2) begin
        pending.push_back('{data: 8'h00, last: 1'b1, status: STATUS_SHORT});
      end else begin
        len = kept.size() - 1;
        if (fletcher_check(kept, len) != kept[len]) begin
          pending.push_back('{data: 8'h00, last: 1'b1, status: STATUS_CHECKSUM});
        end else begin
          for (int i = 0; i < len; i++) begin
            pending.push_back('{data: kept[i], last: (i == len - 1), status: STATUS_GOOD});
          end
        end
      end
      kept.delete();
      mask = 8'h00;
    end else if (b == escape) begin
      mask = unmask;
    end else if (kept.size() < STORE_DEPTH_DEFAULT) begin
      kept.push_back(b ^ mask);
      mask = 8'h00;
    end
  endfunction

  function void check_result(input logic [7:0] data, input logic last, input logic [1:0] status);
    frame_result_t want;
    if (pending.size() == 0) begin
      if (faults < 10) begin
        $display("unexpected result: byte %h last %b status %0d", data, last, status);
      end
      faults++;
    end else begin
      want = pending.pop_front();
      if (want.data !== data || want.last !== last || want.status !== status) begin
        if (faults < 10) begin
          $display("mismatch: expected byte %h last %b status %0d, got byte %h last %b status %0d",
                   want.data, want.last, want.status, data, last, status);
        end
        faults++;
      end
    end
  endfunction

  function int waiting();
    return pending.size();
  endfunction
endclass

module tb_byte_stuffed_frame_receiver_top;

  localparam int STORE_DEPTH = STORE_DEPTH_DEFAULT;

  // every input starts at a known value
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  line_valid = 1'b0;
  logic                  line_stall;
  logic [7:0]            line_byte = 8'h00;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [7:0]            payload_byte;
  logic                  is_last;
  logic [1:0]            frame_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  frame_scoreboard sb = new();

  // idle rates in percent, changed between phases
  int gap_pct   = 8;
  int stall_pct = 61;
  int sent_count = 0;

  byte_stuffed_frame_receiver_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .line_valid(line_valid),
    .line_stall(line_stall),
    .line_byte(line_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .payload_byte(payload_byte),
    .is_last(is_last),
    .frame_status(frame_status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver side: random stall, set at the falling edge
  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // every result transaction is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result(payload_byte, is_last, frame_status);
    end
  end

  // one line transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < gap_pct) begin
      gap++;
    end
    if (gap > 0) begin
      line_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    line_valid <= 1'b1;
    line_byte  <= b;
    do @(posedge clk); while (line_stall);
    sb.note_byte(b);
    sent_count++;
    @(negedge clk);
  endtask

  // sends a decoded byte, escaping it where the current codes need that and
  // now and then where they do not, unless mark and escape share a code; a rare double escape re-arms the mask
  task automatic send_coded(input logic [7:0] d);
    if ((d == sb.mark || d == sb.escape || $urandom_range(7) == 0)
        && sb.escape != sb.mark) begin
      send_byte(sb.escape);
      if ($urandom_range(15) == 0) begin
        send_byte(sb.escape);
      end
      send_byte(d ^ sb.unmask);
    end else begin
      send_byte(d);
    end
  endtask

  // payload, its checksum (spoilt on request), dropped filler, then the mark
  task automatic send_frame(input logic [7:0] body[$], input bit spoil, input int filler);
    logic [7:0] ck;
    logic [7:0] j;
    ck = sb.fletcher_check(body, body.size());
    if (spoil) begin
      ck = ck ^ 8'($urandom_range(1, 255));
    end
    foreach (body[i]) begin
      send_coded(body[i]);
    end
    send_coded(ck);
    repeat (filler) begin
      j = 8'($urandom);
      if (j == sb.mark) begin
        j = sb.escape;
      end
      send_byte(j);
    end
    send_byte(sb.mark);
  endtask

  // sender holds off until the receiver has drained everything predicted
  task automatic pause_until_drained();
    line_valid <= 1'b0;
    do @(negedge clk); while (sb.waiting() != 0);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] m, input logic [7:0] e, input logic [7:0] u);
    write_register(REG_MARK, m);
    write_register(REG_ESCAPE, e);
    write_register(REG_UNMASK, u);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // one frame of a randomly chosen kind; mostly well-formed
  task automatic send_random_frame();
    logic [7:0] body[$];
    int kind;
    int len;
    kind = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
    if (kind >= 82 && kind < 92) begin
      len = $urandom_range(1, 12);
    end else if (kind >= 92 && kind < 95) begin
      len = STORE_DEPTH - 1;
    end
    repeat (len) body.push_back(8'($urandom));
    if (kind < 62) begin
      send_frame(body, 1'b0, 0);
    end else if (kind < 74) begin
      send_frame(body, 1'b1, 0);
    end else if (kind < 82) begin
      // too short: nothing or a lone byte before the mark
      if ($urandom_range(1) == 1) begin
        send_byte(body[0]);
      end
      send_byte(sb.mark);
    end else if (kind < 92) begin
      // noise, with marks and escapes sprinkled in
      foreach (body[i]) begin
        case ($urandom_range(9))
          0: send_byte(sb.mark);
          1: send_byte(sb.escape);
          default: send_byte(body[i]);
        endcase
      end
      send_byte(sb.mark);
    end else if (kind < 95) begin
      // fills the store, checksum in the last slot, the rest dropped
      send_frame(body, 1'b0, $urandom_range(1, 6));
    end else begin
      // escape straight before the mark
      foreach (body[i]) begin
        send_coded(body[i]);
      end
      send_byte(sb.escape);
      send_byte(sb.mark);
    end
  endtask

  initial begin
    logic [7:0] m;
    logic [7:0] e;
    logic [7:0] u;
    logic [7:0] ck;
    int phase_start;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values, written once explicitly
    apply_settings(MARK_RESET, ESCAPE_RESET, UNMASK_RESET);

    // directed: empty frame, lone byte, extremes, escaped codes
    send_byte(sb.mark);
    send_byte(8'h00);
    send_byte(sb.mark);
    send_frame('{8'hFF}, 1'b0, 0);
    send_frame('{sb.mark, sb.escape, 8'h00}, 1'b0, 0);

    // double escape: the second one re-arms the same mask
    ck = sb.fletcher_check('{8'h5A}, 1);
    send_byte(sb.escape);
    send_byte(sb.escape);
    send_byte(8'h5A ^ sb.unmask);
    send_byte(ck);
    send_byte(sb.mark);

    // escape then mark, after which no mask may linger
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(sb.escape);
    send_byte(sb.mark);
    send_frame('{8'h40}, 1'b0, 0);

    // checksum mismatch
    send_frame('{8'h80, 8'h01}, 1'b1, 0);

    // random phases, each under its own codes and idle pattern
    for (int phase = 0; phase < 6; phase++) begin
      pause_until_drained();
      repeat (8) @(negedge clk);
      case (phase)
        0: begin
          m = MARK_RESET;
          e = ESCAPE_RESET;
          u = UNMASK_RESET;
        end
        1: begin
          m = 8'h00;
          e = 8'hFF;
          u = 8'hFF;
        end
        2: begin
          m = 8'hFF;
          e = 8'h00;
          u = 8'h00;
        end
        3: begin
          // mark and escape share a code: the mark meaning wins
          m = 8'h55;
          e = 8'h55;
          u = 8'hAA;
        end
        4: begin
          m = 8'($urandom);
          do e = 8'($urandom); while (e == m);
          u = 8'($urandom);
        end
        default: begin
          m = 8'($urandom);
          e = 8'($urandom);
          u = 8'($urandom);
        end
      endcase
      apply_settings(m, e, u);

      if (phase < 2) begin
        gap_pct   = 8;
        stall_pct = 61;
      end else if (phase < 4) begin
        gap_pct   = 61;
        stall_pct = 8;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end

      phase_start = sent_count;
      while (sent_count - phase_start < 50) begin
        send_random_frame();
        if ($urandom_range(9) == 0) begin
          pause_until_drained();
        end
      end
    end

    // let the last frames drain, then a short settling time
    pause_until_drained();
    repeat (16) @(negedge clk);

    if (sb.faults == 0 && sb.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bsfr_pkg.sv
rtl/bsfr_ctrl.sv
rtl/bsfr_dpath.sv
rtl/byte_stuffed_frame_receiver_top.sv
test/tb_byte_stuffed_frame_receiver_top.sv
